[rtl/core/min_heap_timer_queue_top_assert.svh]
// Assertion macros used by the timer queue port checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef MIN_HEAP_TIMER_QUEUE_TOP_ASSERT_SVH
`define MIN_HEAP_TIMER_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MHTQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("timer queue check failed");

// Next-cycle implication, disabled during reset.
`define MHTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("timer queue check failed");

`endif

[rtl/core/mhtq_pkg.sv]
// Shared types and constants of the min-heap timer queue.
// No dependencies; used by the top level and its port checker.
package mhtq_pkg;

    localparam int TIME_W    = 48;
    localparam int DELAY_W   = 32;
    localparam int PTAG_W    = 8;
    localparam int WAIT_W    = 32;
    localparam int ENTRIES_W = 7;
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 3;

    typedef logic [1:0]        t_kind;
    typedef logic [TIME_W-1:0] t_time;

    localparam t_kind KIND_DELAY    = 2'd0;
    localparam t_kind KIND_AT       = 2'd1;
    localparam t_kind KIND_PERIODIC = 2'd2;
    localparam t_kind KIND_TICK     = 2'd3;

    localparam t_time TIME_MAX = 48'hFFFF_FFFF_FFFF;

    // Result flag positions in m_axis_tuser.
    localparam int USER_FIRED   = 0;
    localparam int USER_DROPPED = 1;
    localparam int USER_EMPTY   = 2;

endpackage

[rtl/core/min_heap_timer_queue_top.sv]
// Min-heap timer queue: heap memories, sift sequencer and result register.
// Depends on mhtq_pkg.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser kind, tdata now/delay/at/tag
//  m_axis    out  m_axis_tvalid/m_axis_tready   tuser flags, tdata tag/wait/entries
//
// Steps: an add climbs in S_UP/S_UP_CMP, then reads the top in S_TOP_RD/S_TOP_DIFF;
// a tick pops the root in S_POP_RD/S_POP_LD, sinks in S_DN/S_DN_CMP and climbs again
// from S_RELOAD when the timer reloads; a dropped item or an empty tick goes straight to
// S_TOP_RD. Each level is one heap memory read; levels are bounded by log2(HEAP_DEPTH).
// Reset (i_rst_n low, synchronous) empties the heap; the memories keep their data.
// s_axis_tready is high only in idle; a stalled result holds the sequencer in S_OUT.
module min_heap_timer_queue_top #(
    parameter int HEAP_DEPTH = 64,
    parameter int TAG_WIDTH  = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [47:0] now_ms, [79:48] delay_ms, [127:80] at_time_ms, [135:128] task_tag
    input  logic [mhtq_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] fired_tag, [39:8] wait_ms, [46:40] entries, [47] zero
    output logic [mhtq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // [0] fired, [1] dropped, [2] heap_empty
    output logic [mhtq_pkg::OUT_USER_W-1:0]   m_axis_tuser
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int PW = $clog2(HEAP_DEPTH + 1);
    localparam int CW = PW + 1;
    localparam int TW = mhtq_pkg::TIME_W;
    localparam int DW = mhtq_pkg::DELAY_W;

    // Sequencer codes.
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_UP       = 4'd1;
    localparam logic [3:0] S_UP_CMP   = 4'd2;
    localparam logic [3:0] S_POP_RD   = 4'd3;
    localparam logic [3:0] S_POP_LD   = 4'd4;
    localparam logic [3:0] S_DN       = 4'd5;
    localparam logic [3:0] S_DN_CMP   = 4'd6;
    localparam logic [3:0] S_RELOAD   = 4'd7;
    localparam logic [3:0] S_TOP_RD   = 4'd8;
    localparam logic [3:0] S_TOP_DIFF = 4'd9;
    localparam logic [3:0] S_OUT      = 4'd10;

    // Heap memories, one slot per timer, shared address.
    logic [TW-1:0]        r_mem_dl [HEAP_DEPTH];
    logic [DW-1:0]        r_mem_iv [HEAP_DEPTH];
    logic [TAG_WIDTH-1:0] r_mem_tg [HEAP_DEPTH];

    logic [TW-1:0]        r_rda_dl, r_rdb_dl;
    logic [DW-1:0]        r_rda_iv, r_rdb_iv;
    logic [TAG_WIDTH-1:0] r_rda_tg, r_rdb_tg;

    logic                 mem_we;
    logic [AW-1:0]        mem_wa, rd_a_addr, rd_b_addr;
    logic [TW-1:0]        mem_wdl;
    logic [DW-1:0]        mem_wiv;
    logic [TAG_WIDTH-1:0] mem_wtg;

    // Sequencer and item state.
    logic [3:0]           r_state, n_state;
    logic [PW-1:0]        r_count, n_count;
    logic [PW-1:0]        r_pos, n_pos;
    logic [TW-1:0]        r_x_dl, n_x_dl;
    logic [DW-1:0]        r_x_iv, n_x_iv;
    logic [TAG_WIDTH-1:0] r_x_tg, n_x_tg;
    logic [TW-1:0]        r_now, n_now;
    logic [DW-1:0]        r_top_iv, n_top_iv;
    logic                 r_fired, n_fired;
    logic [TAG_WIDTH-1:0] r_fired_tag, n_fired_tag;
    logic                 r_dropped, n_dropped;
    logic [TW-1:0]        r_diff, n_diff;

    // Result register.
    logic                                r_out_valid, n_out_valid;
    logic [mhtq_pkg::OUT_DATA_W-1:0]     r_out_data, n_out_data;
    logic [mhtq_pkg::OUT_USER_W-1:0]     r_out_user, n_out_user;

    // Input fields.
    logic [TW-1:0]               in_now, in_at;
    logic [DW-1:0]               in_delay;
    logic [mhtq_pkg::PTAG_W-1:0] in_tag;
    mhtq_pkg::t_kind             in_kind;

    assign in_now   = s_axis_tdata[47:0];
    assign in_delay = s_axis_tdata[79:48];
    assign in_at    = s_axis_tdata[127:80];
    assign in_tag   = s_axis_tdata[135:128];
    assign in_kind  = s_axis_tuser;

    logic in_accept;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Shared saturating deadline adder: the new item in idle, the reload otherwise.
    logic [TW-1:0] add_a;
    logic [DW-1:0] add_b;
    logic [TW:0]   add_sum;
    logic [TW-1:0] add_sat;

    assign add_a   = (r_state == S_IDLE) ? in_now : r_now;
    assign add_b   = (r_state == S_IDLE) ? in_delay : r_top_iv;
    assign add_sum = {1'b0, add_a} + {{(TW + 1 - DW){1'b0}}, add_b};
    assign add_sat = add_sum[TW] ? mhtq_pkg::TIME_MAX : add_sum[TW-1:0];

    // Heap position arithmetic (positions are 1-based).
    logic [AW-1:0] pos_slot, parent_slot, lchild_slot, rchild_slot;
    logic [PW-1:0] parent_pos;
    logic [CW-1:0] lchild_pos, rchild_pos, count_ext;

    assign pos_slot    = AW'(r_pos - 1'b1);
    assign parent_pos  = r_pos >> 1;
    assign parent_slot = AW'(parent_pos - 1'b1);
    assign lchild_pos  = {r_pos, 1'b0};
    assign rchild_pos  = {r_pos, 1'b1};
    assign lchild_slot = AW'(lchild_pos - 1'b1);
    assign rchild_slot = AW'(lchild_pos);
    assign count_ext   = {1'b0, r_count};

    // Sift compares: strictly smaller moves, left child wins a tie.
    logic lt_up, lt_lx, lt_rl, lt_rx, rc_in_heap;
    assign lt_up      = r_x_dl < r_rda_dl;
    assign lt_lx      = r_rda_dl < r_x_dl;
    assign lt_rl      = r_rdb_dl < r_rda_dl;
    assign lt_rx      = r_rdb_dl < r_x_dl;
    assign rc_in_heap = rchild_pos <= count_ext;

    // Distance from now to the top deadline.
    logic [TW:0]   top_minus_now;
    logic [TW-1:0] now_minus_top;
    assign top_minus_now = {1'b0, r_rda_dl} - {1'b0, r_now};
    assign now_minus_top = r_now - r_rda_dl;

    logic [mhtq_pkg::WAIT_W-1:0] wait_val;
    always_comb begin
        if (r_count == '0) begin
            wait_val = '0;
        end else if (r_diff == '0) begin
            wait_val = mhtq_pkg::WAIT_W'(1);
        end else if (|r_diff[TW-1:mhtq_pkg::WAIT_W]) begin
            wait_val = '1;
        end else begin
            wait_val = r_diff[mhtq_pkg::WAIT_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_x_dl      = r_x_dl;
        n_x_iv      = r_x_iv;
        n_x_tg      = r_x_tg;
        n_now       = r_now;
        n_top_iv    = r_top_iv;
        n_fired     = r_fired;
        n_fired_tag = r_fired_tag;
        n_dropped   = r_dropped;
        n_diff      = r_diff;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        mem_we      = 1'b0;
        mem_wa      = pos_slot;
        mem_wdl     = r_x_dl;
        mem_wiv     = r_x_iv;
        mem_wtg     = r_x_tg;
        rd_a_addr   = '0;
        rd_b_addr   = AW'(r_count - 1'b1);

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_now       = in_now;
                    n_fired     = 1'b0;
                    n_fired_tag = '0;
                    n_dropped   = 1'b0;
                    n_x_tg      = TAG_WIDTH'(in_tag);
                    n_x_dl      = (in_kind == mhtq_pkg::KIND_AT) ? in_at : add_sat;
                    n_x_iv      = (in_kind == mhtq_pkg::KIND_PERIODIC) ? in_delay : '0;
                    n_pos       = r_count + 1'b1;
                    if (in_kind == mhtq_pkg::KIND_TICK) begin
                        n_state = (r_count == '0) ? S_TOP_RD : S_POP_RD;
                    end else if (r_count == PW'(HEAP_DEPTH)) begin
                        n_dropped = 1'b1;
                        n_state   = S_TOP_RD;
                    end else if (in_kind == mhtq_pkg::KIND_AT && in_at < in_now) begin
                        n_dropped = 1'b1;
                        n_state   = S_TOP_RD;
                    end else begin
                        n_count = r_count + 1'b1;
                        n_state = S_UP;
                    end
                end
            end
            S_UP: begin
                rd_a_addr = parent_slot;
                if (r_pos == PW'(1)) begin
                    mem_we  = 1'b1;
                    n_state = S_TOP_RD;
                end else begin
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                // Move the parent down into the hole, or settle the new timer.
                mem_we = 1'b1;
                if (lt_up) begin
                    mem_wdl = r_rda_dl;
                    mem_wiv = r_rda_iv;
                    mem_wtg = r_rda_tg;
                    n_pos   = parent_pos;
                    n_state = S_UP;
                end else begin
                    n_state = S_TOP_RD;
                end
            end
            S_POP_RD: begin
                rd_a_addr = '0;
                n_state   = S_POP_LD;
            end
            S_POP_LD: begin
                n_fired     = 1'b1;
                n_fired_tag = r_rda_tg;
                n_top_iv    = r_rda_iv;
                n_x_dl      = r_rdb_dl;
                n_x_iv      = r_rdb_iv;
                n_x_tg      = r_rdb_tg;
                n_count     = r_count - 1'b1;
                n_pos       = PW'(1);
                n_state     = S_DN;
            end
            S_DN: begin
                rd_a_addr = lchild_slot;
                rd_b_addr = rchild_slot;
                if (lchild_pos > count_ext) begin
                    mem_we  = 1'b1;
                    n_state = S_RELOAD;
                end else begin
                    n_state = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                mem_we = 1'b1;
                if (rc_in_heap && (lt_lx ? lt_rl : lt_rx)) begin
                    mem_wdl = r_rdb_dl;
                    mem_wiv = r_rdb_iv;
                    mem_wtg = r_rdb_tg;
                    n_pos   = PW'(rchild_pos);
                    n_state = S_DN;
                end else if (lt_lx) begin
                    mem_wdl = r_rda_dl;
                    mem_wiv = r_rda_iv;
                    mem_wtg = r_rda_tg;
                    n_pos   = PW'(lchild_pos);
                    n_state = S_DN;
                end else begin
                    n_state = S_RELOAD;
                end
            end
            S_RELOAD: begin
                // Put a periodic timer back at now plus its interval.
                if (r_top_iv != '0) begin
                    n_x_dl  = add_sat;
                    n_x_iv  = r_top_iv;
                    n_x_tg  = r_fired_tag;
                    n_pos   = r_count + 1'b1;
                    n_count = r_count + 1'b1;
                    n_state = S_UP;
                end else begin
                    n_state = S_TOP_RD;
                end
            end
            S_TOP_RD: begin
                rd_a_addr = '0;
                n_state   = S_TOP_DIFF;
            end
            S_TOP_DIFF: begin
                n_diff  = top_minus_now[TW] ? now_minus_top : top_minus_now[TW-1:0];
                n_state = S_OUT;
            end
            S_OUT: begin
                // Hold until the result register is free.
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, mhtq_pkg::ENTRIES_W'(r_count), wait_val,
                                   mhtq_pkg::PTAG_W'(r_fired_tag)};
                    n_out_user  = {(r_count == '0), r_dropped, r_fired};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_dl[mem_wa] <= mem_wdl;
            r_mem_iv[mem_wa] <= mem_wiv;
            r_mem_tg[mem_wa] <= mem_wtg;
        end
        r_rda_dl <= r_mem_dl[rd_a_addr];
        r_rda_iv <= r_mem_iv[rd_a_addr];
        r_rda_tg <= r_mem_tg[rd_a_addr];
        r_rdb_dl <= r_mem_dl[rd_b_addr];
        r_rdb_iv <= r_mem_iv[rd_b_addr];
        r_rdb_tg <= r_mem_tg[rd_b_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_x_dl      <= n_x_dl;
        r_x_iv      <= n_x_iv;
        r_x_tg      <= n_x_tg;
        r_now       <= n_now;
        r_top_iv    <= n_top_iv;
        r_fired     <= n_fired;
        r_fired_tag <= n_fired_tag;
        r_dropped   <= n_dropped;
        r_diff      <= n_diff;
        r_out_data  <= n_out_data;
        r_out_user  <= n_out_user;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

[rtl/core/mhtq_checker.sv]
// Port-level checker for the min-heap timer queue, bound to the top level.
// Depends on mhtq_pkg and min_heap_timer_queue_top_assert.svh.
`include "min_heap_timer_queue_top_assert.svh"

module mhtq_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [mhtq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic [mhtq_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

    // A stalled result holds.
    `MHTQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // The block is busy in the cycle after it takes an item.
    `MHTQ_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // An empty heap reports no wait and no entries.
    `MHTQ_ASSERT_NOW(a_empty_fields, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[mhtq_pkg::USER_EMPTY], m_axis_tdata[39:8] == 32'd0 && m_axis_tdata[46:40] == 7'd0)

    // A nonempty heap always reports a wait of at least one.
    `MHTQ_ASSERT_NOW(a_wait_nonzero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[mhtq_pkg::USER_EMPTY], m_axis_tdata[39:8] != 32'd0)

endmodule

bind min_heap_timer_queue_top mhtq_checker u_mhtq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
